/* design/thq_pkg.sv */
// shared types, constants and field layout for the terrain height query block
// no dependencies; imported by every design module
`default_nettype none

package thq_pkg;

    // default heightmap edge length in samples
    localparam int GRID_MAX_DEFAULT = 256;
    // fraction bits of query positions and interpolation weights
    localparam int FRAC_BITS = 8;

    localparam int CORNER_W   = 18;  // signed corner after the triangle fix-up
    localparam int QUERY_W    = 18;
    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 16;
    localparam int COORD_W    = 8;   // cell coordinates never pass the 8-bit extent
    localparam int GRID_W     = 9;
    localparam int EXTENT_W   = 8;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    // placement of the input fields in s_tdata
    localparam int LOAD_INDEX_LSB = 0;
    localparam int LOAD_VALUE_LSB = LOAD_INDEX_LSB + INDEX_W;
    localparam int QUERY_X_LSB    = LOAD_VALUE_LSB + SAMPLE_W;
    localparam int QUERY_Z_LSB    = QUERY_X_LSB + QUERY_W;

    // shifted position width: holds the query plus half the extent, with sign
    localparam int PX_W = ((QUERY_W > EXTENT_W + FRAC_BITS) ?
                           QUERY_W : EXTENT_W + FRAC_BITS) + 2;

    // interpolation widths
    localparam int TOP_W = CORNER_W + FRAC_BITS + 3;
    localparam int H_W   = TOP_W + FRAC_BITS + 3;
    localparam int HF_W  = H_W - 1 - FRAC_BITS;
    localparam int P_W   = HF_W + SCALE_W;
    localparam int Q_W   = P_W + 1;
    localparam int V_W   = Q_W - FRAC_BITS;

    localparam logic [63:0] SAMPLE_MAX = 64'd65535;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIZE    = 2'd0,
        REG_EXTENT_X     = 2'd1,
        REG_EXTENT_Z     = 2'd2,
        REG_HEIGHT_SCALE = 2'd3
    } thq_reg_idx_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } thq_cmd_t;

    // one classified transaction as it waits in the queue
    typedef struct packed {
        logic                 is_query;
        logic                 in_range;
        logic                 load_ok;
        logic [INDEX_W-1:0]   load_index;
        logic [SAMPLE_W-1:0]  load_value;
        logic [COORD_W-1:0]   x0;
        logic [COORD_W-1:0]   x1;
        logic [COORD_W-1:0]   z0;
        logic [COORD_W-1:0]   z1;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fz;
    } thq_item_t;

    // corners and weights leaving the sample fetch
    typedef struct packed {
        logic                 valid;
        logic                 in_range;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fz;
        logic [SAMPLE_W-1:0]  bl;
        logic [SAMPLE_W-1:0]  br;
        logic [SAMPLE_W-1:0]  tl;
        logic [SAMPLE_W-1:0]  tr;
    } thq_fetch_t;

endpackage

`default_nettype wire

/* design/thq_front.sv */
// front end: takes input transactions, splits loads from queries and works out
// the cell corners and fractions; depends on thq_pkg
`default_nettype none

module thq_front import thq_pkg::*; #(
    parameter int GRID_MAX = GRID_MAX_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic [GRID_W-1:0]    grid_g,
    input  wire logic [EXTENT_W-1:0]  extent_x,
    input  wire logic [EXTENT_W-1:0]  extent_z,
    output logic                      item_valid,
    output thq_item_t                 item,
    input  wire logic                 queue_ready
);

    localparam int STORE_DEPTH = GRID_MAX * GRID_MAX;

    logic      front_valid_reg;
    thq_item_t front_item_reg;
    thq_item_t item_next;

    logic signed [QUERY_W-1:0] qx;
    logic signed [QUERY_W-1:0] qz;
    logic signed [PX_W-1:0]    px;
    logic signed [PX_W-1:0]    pz;
    logic signed [PX_W-1:0]    limit_x;
    logic signed [PX_W-1:0]    limit_z;
    logic [COORD_W-1:0]        cx;
    logic [COORD_W-1:0]        cz;
    logic [GRID_W-1:0]         gm1;
    logic [GRID_W-1:0]         cx_inc;
    logic [GRID_W-1:0]         cz_inc;
    logic                      on_terrain;

    assign s_tready   = !front_valid_reg || queue_ready;
    assign item_valid = front_valid_reg;
    assign item       = front_item_reg;

    always_comb begin
        qx = s_tdata[QUERY_X_LSB +: QUERY_W];
        qz = s_tdata[QUERY_Z_LSB +: QUERY_W];
        px = PX_W'(qx) + (PX_W'(extent_x) << (FRAC_BITS - 1));
        pz = PX_W'(qz) + (PX_W'(extent_z) << (FRAC_BITS - 1));
        limit_x = PX_W'(extent_x) << FRAC_BITS;
        limit_z = PX_W'(extent_z) << FRAC_BITS;
        on_terrain = !px[PX_W-1] && !pz[PX_W-1] && (px < limit_x) && (pz < limit_z);

        cx = px[FRAC_BITS +: COORD_W];
        cz = pz[FRAC_BITS +: COORD_W];
        gm1 = grid_g - GRID_W'(1);
        cx_inc = GRID_W'(cx) + GRID_W'(1);
        cz_inc = GRID_W'(cz) + GRID_W'(1);

        item_next.is_query   = (s_tuser == CMD_QUERY);
        item_next.in_range   = (s_tuser == CMD_QUERY) && on_terrain;
        item_next.load_index = s_tdata[LOAD_INDEX_LSB +: INDEX_W];
        item_next.load_value = s_tdata[LOAD_VALUE_LSB +: SAMPLE_W];
        item_next.load_ok    = 32'(s_tdata[LOAD_INDEX_LSB +: INDEX_W]) < 32'(STORE_DEPTH);

        // neighbours clamp to the last row and column in use
        item_next.x0 = (GRID_W'(cx) > gm1) ? gm1[COORD_W-1:0] : cx;
        item_next.x1 = (cx_inc > gm1) ? gm1[COORD_W-1:0] : cx_inc[COORD_W-1:0];
        item_next.z0 = (GRID_W'(cz) > gm1) ? gm1[COORD_W-1:0] : cz;
        item_next.z1 = (cz_inc > gm1) ? gm1[COORD_W-1:0] : cz_inc[COORD_W-1:0];
        item_next.fx = px[FRAC_BITS-1:0];
        item_next.fz = pz[FRAC_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_tready) begin
            front_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            front_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

/* design/thq_queue.sv */
// short queue between the front end and the sample fetch
// depends on thq_pkg
`default_nettype none

module thq_queue import thq_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire thq_item_t  in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output thq_item_t       out_item
);

    thq_item_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W:0]     count_reg;
    logic [QUEUE_PTR_W:0]     count_next;
    logic                     push;
    logic                     pop;

    assign in_ready  = (count_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_PTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* design/thq_fetch.sv */
// sample fetch: corner addresses, then the heightmap store (one copy per corner row,
// each read at two addresses); loads are written here in transaction order; uses thq_pkg
`default_nettype none

module thq_fetch import thq_pkg::*; #(
    parameter int GRID_MAX = GRID_MAX_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              enable,
    input  wire logic              item_valid,
    input  wire thq_item_t         item,
    input  wire logic [GRID_W-1:0] grid_g,
    output thq_fetch_t             fetch_o
);

    localparam int STORE_DEPTH = GRID_MAX * GRID_MAX;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int LIN_W       = 2 * GRID_W + 1;

    // address stage
    logic                 a_valid_reg;
    logic                 a_write_reg;
    logic                 a_in_range_reg;
    logic [FRAC_BITS-1:0] a_fx_reg;
    logic [FRAC_BITS-1:0] a_fz_reg;
    logic [AW-1:0]        a_load_addr_reg;
    logic [SAMPLE_W-1:0]  a_load_value_reg;
    logic [AW-1:0]        a_bl_addr_reg;
    logic [AW-1:0]        a_br_addr_reg;
    logic [AW-1:0]        a_tl_addr_reg;
    logic [AW-1:0]        a_tr_addr_reg;

    logic [LIN_W-1:0]     row0_base;
    logic [LIN_W-1:0]     row1_base;

    // read stage
    logic                 b_valid_reg;
    logic                 b_in_range_reg;
    logic [FRAC_BITS-1:0] b_fx_reg;
    logic [FRAC_BITS-1:0] b_fz_reg;
    logic [SAMPLE_W-1:0]  b_bl_reg;
    logic [SAMPLE_W-1:0]  b_br_reg;
    logic [SAMPLE_W-1:0]  b_tl_reg;
    logic [SAMPLE_W-1:0]  b_tr_reg;

    logic [SAMPLE_W-1:0]  store_bottom [STORE_DEPTH];
    logic [SAMPLE_W-1:0]  store_top [STORE_DEPTH];

    always_comb begin
        row0_base = LIN_W'(item.z0) * LIN_W'(grid_g);
        row1_base = LIN_W'(item.z1) * LIN_W'(grid_g);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (enable) begin
            a_valid_reg <= item_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            a_write_reg      <= item_valid && !item.is_query && item.load_ok;
            a_in_range_reg   <= item.in_range;
            a_fx_reg         <= item.fx;
            a_fz_reg         <= item.fz;
            a_load_addr_reg  <= AW'(item.load_index);
            a_load_value_reg <= item.load_value;
            a_bl_addr_reg    <= AW'(row0_base + LIN_W'(item.x0));
            a_br_addr_reg    <= AW'(row0_base + LIN_W'(item.x1));
            a_tl_addr_reg    <= AW'(row1_base + LIN_W'(item.x0));
            a_tr_addr_reg    <= AW'(row1_base + LIN_W'(item.x1));

            b_in_range_reg <= a_in_range_reg;
            b_fx_reg       <= a_fx_reg;
            b_fz_reg       <= a_fz_reg;
        end
    end

    // a load and a later query meet the store in the same stage, so order holds
    always_ff @(posedge aclk) begin
        if (enable) begin
            if (a_valid_reg && a_write_reg) begin
                store_bottom[a_load_addr_reg] <= a_load_value_reg;
            end
            b_bl_reg <= store_bottom[a_bl_addr_reg];
            b_br_reg <= store_bottom[a_br_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            if (a_valid_reg && a_write_reg) begin
                store_top[a_load_addr_reg] <= a_load_value_reg;
            end
            b_tl_reg <= store_top[a_tl_addr_reg];
            b_tr_reg <= store_top[a_tr_addr_reg];
        end
    end

    always_comb begin
        fetch_o.valid    = b_valid_reg;
        fetch_o.in_range = b_in_range_reg;
        fetch_o.fx       = b_fx_reg;
        fetch_o.fz       = b_fz_reg;
        fetch_o.bl       = b_bl_reg;
        fetch_o.br       = b_br_reg;
        fetch_o.tl       = b_tl_reg;
        fetch_o.tr       = b_tr_reg;
    end

endmodule

`default_nettype wire

/* design/thq_interp.sv */
// interpolation pipeline: triangle fix-up, x then z blend, scaling, rounding,
// divide by 65535 and the result register; depends on thq_pkg
`default_nettype none

module thq_interp import thq_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire thq_fetch_t          fetch_i,
    input  wire logic [SCALE_W-1:0]  height_scale,
    output logic                     enable,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_TDATA_W-1:0]     m_tdata,   // [15:0] height
    output logic                     m_tuser    // [0] in_range
);

    localparam logic [FRAC_BITS:0] ONE_S    = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0]     HALF_DEN = Q_W'(SAMPLE_MAX << (FRAC_BITS - 1));
    localparam logic [V_W-1:0]     SAT_LIM  = V_W'(SAMPLE_MAX << 16);
    localparam logic [16:0]        ONE_DIV  = 17'(SAMPLE_MAX);
    localparam logic [16:0]        TWO_DIV  = 17'(SAMPLE_MAX << 1);

    // fix-up stage
    logic                        c_valid_reg;
    logic                        c_in_range_reg;
    logic [FRAC_BITS-1:0]        c_fx_reg;
    logic [FRAC_BITS-1:0]        c_fz_reg;
    logic signed [CORNER_W-1:0]  c_bl_reg;
    logic signed [CORNER_W-1:0]  c_br_reg;
    logic signed [CORNER_W-1:0]  c_tl_reg;
    logic signed [CORNER_W-1:0]  c_tr_reg;
    logic signed [CORNER_W-1:0]  bl_s;
    logic signed [CORNER_W-1:0]  br_s;
    logic signed [CORNER_W-1:0]  tl_s;
    logic signed [CORNER_W-1:0]  tr_s;
    logic signed [CORNER_W-1:0]  br_next;
    logic signed [CORNER_W-1:0]  tl_next;

    // x blend stage
    logic                        d_valid_reg;
    logic                        d_in_range_reg;
    logic [FRAC_BITS-1:0]        d_fz_reg;
    logic signed [TOP_W-1:0]     d_top_reg;
    logic signed [TOP_W-1:0]     d_bot_reg;
    logic signed [TOP_W-1:0]     wx_s;
    logic signed [TOP_W-1:0]     fx_s;
    logic [FRAC_BITS:0]          wx;

    // z blend stage
    logic                        e_valid_reg;
    logic                        e_in_range_reg;
    logic signed [H_W-1:0]       e_h_reg;
    logic signed [H_W-1:0]       wz_s;
    logic signed [H_W-1:0]       fz_s;
    logic [FRAC_BITS:0]          wz;

    // scale stage
    logic                        f_valid_reg;
    logic                        f_in_range_reg;
    logic [P_W-1:0]              f_prod_reg;
    logic [HF_W-1:0]             hf;

    // rounding stage
    logic                        g_valid_reg;
    logic                        g_in_range_reg;
    logic [Q_W-1:0]              g_sum_reg;

    // result register
    logic                        out_valid_reg;
    logic                        out_in_range_reg;
    logic [M_TDATA_W-1:0]        out_height_reg;
    logic [M_TDATA_W-1:0]        height_next;
    logic [V_W-1:0]              v;
    logic [15:0]                 q_est;
    logic [16:0]                 rem;

    assign enable   = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_height_reg;
    assign m_tuser  = out_in_range_reg;

    // one corner is rebuilt so the cell splits into two planar triangles
    always_comb begin
        bl_s = CORNER_W'(fetch_i.bl);
        br_s = CORNER_W'(fetch_i.br);
        tl_s = CORNER_W'(fetch_i.tl);
        tr_s = CORNER_W'(fetch_i.tr);
        if (fetch_i.fz >= fetch_i.fx) begin
            br_next = bl_s + (tr_s - tl_s);
            tl_next = tl_s;
        end else begin
            br_next = br_s;
            tl_next = tr_s + (bl_s - br_s);
        end
    end

    always_comb begin
        wx   = ONE_S - (FRAC_BITS + 1)'(c_fx_reg);
        wx_s = TOP_W'(wx);
        fx_s = TOP_W'(c_fx_reg);
        wz   = ONE_S - (FRAC_BITS + 1)'(d_fz_reg);
        wz_s = H_W'(wz);
        fz_s = H_W'(d_fz_reg);
        // negative heights clamp to zero before the fraction bits drop
        hf   = e_h_reg[H_W-1] ? '0 : e_h_reg[H_W-2:FRAC_BITS];
    end

    // divide by 65535: v = q*65536 + lo = q*65535 + (q + lo), at most two corrections
    always_comb begin
        v      = g_sum_reg[Q_W-1:FRAC_BITS];
        q_est  = v[31:16];
        rem    = 17'(v[15:0]) + 17'(q_est);
        if (!g_in_range_reg) begin
            height_next = '0;
        end else if (v >= SAT_LIM) begin
            height_next = '1;
        end else begin
            height_next = q_est + 16'(rem >= ONE_DIV) + 16'(rem >= TWO_DIV);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (enable) begin
            c_valid_reg   <= fetch_i.valid;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= f_valid_reg;
            out_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            c_in_range_reg <= fetch_i.in_range;
            c_fx_reg       <= fetch_i.fx;
            c_fz_reg       <= fetch_i.fz;
            c_bl_reg       <= bl_s;
            c_br_reg       <= br_next;
            c_tl_reg       <= tl_next;
            c_tr_reg       <= tr_s;

            d_in_range_reg <= c_in_range_reg;
            d_fz_reg       <= c_fz_reg;
            d_top_reg      <= TOP_W'(c_tl_reg) * wx_s + TOP_W'(c_tr_reg) * fx_s;
            d_bot_reg      <= TOP_W'(c_bl_reg) * wx_s + TOP_W'(c_br_reg) * fx_s;

            e_in_range_reg <= d_in_range_reg;
            e_h_reg        <= H_W'(d_bot_reg) * wz_s + H_W'(d_top_reg) * fz_s;

            f_in_range_reg <= e_in_range_reg;
            f_prod_reg     <= P_W'(hf) * P_W'(height_scale);

            g_in_range_reg <= f_in_range_reg;
            g_sum_reg      <= Q_W'(f_prod_reg) + HALF_DEN;

            out_in_range_reg <= g_in_range_reg;
            out_height_reg   <= height_next;
        end
    end

endmodule

`default_nettype wire

/* design/terrain_height_query.sv */
// Terrain height query. Holds a square heightmap of 16-bit samples, loaded one
// sample per transaction, and answers height queries at signed Q.8 positions
// measured from the terrain centre. Every input transaction yields exactly one
// result, in order: loads return zero, off-terrain queries return zero with
// in_range clear. The block takes one transaction per clock and returns one
// result per clock while m_tready stays high; a query's result passes through
// the front register, the queue and the eight-stage fetch and interpolation
// pipeline. The whole back end halts while a result waits; the four-entry
// queue keeps the input side open meanwhile.
// The heightmap is held twice (one copy per corner row, two read addresses
// each); samples read before they were ever loaded give undefined heights.
// No clearing pass runs after reset. Configuration writes are always accepted
// and must only occur while the block is idle.
// depends on thq_pkg, thq_front, thq_queue, thq_fetch, thq_interp
`default_nettype none

module terrain_height_query import thq_pkg::*; #(
    parameter int GRID_MAX = GRID_MAX_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [15:0] load_index, [31:16] load_value, [49:32] query_x, [67:50] query_z,
    // [71:68] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,   // [0] command

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [15:0] height
    output logic                       m_tuser,   // [0] in_range

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [GRID_W-1:0]   grid_size_reg;
    logic [EXTENT_W-1:0] extent_x_reg;
    logic [EXTENT_W-1:0] extent_z_reg;
    logic [SCALE_W-1:0]  height_scale_reg;
    logic [GRID_W-1:0]   grid_g;

    logic       front_valid;
    thq_item_t  front_item;
    logic       queue_ready;
    logic       queue_valid;
    thq_item_t  queue_item;
    logic       enable;
    thq_fetch_t fetch_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg    <= GRID_W'(256);
            extent_x_reg     <= EXTENT_W'(255);
            extent_z_reg     <= EXTENT_W'(255);
            height_scale_reg <= SCALE_W'(256);
        end else if (cfg_valid && cfg_ready) begin
            unique case (thq_reg_idx_t'(cfg_index))
                REG_GRID_SIZE:    grid_size_reg    <= cfg_data[GRID_W-1:0];
                REG_EXTENT_X:     extent_x_reg     <= cfg_data[EXTENT_W-1:0];
                REG_EXTENT_Z:     extent_z_reg     <= cfg_data[EXTENT_W-1:0];
                REG_HEIGHT_SCALE: height_scale_reg <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // grid size in use, held within two and the store edge
    always_comb begin
        if (grid_size_reg < GRID_W'(2)) begin
            grid_g = GRID_W'(2);
        end else if (32'(grid_size_reg) > 32'(GRID_MAX)) begin
            grid_g = GRID_W'(GRID_MAX);
        end else begin
            grid_g = grid_size_reg;
        end
    end

    thq_front #(
        .GRID_MAX (GRID_MAX)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .grid_g      (grid_g),
        .extent_x    (extent_x_reg),
        .extent_z    (extent_z_reg),
        .item_valid  (front_valid),
        .item        (front_item),
        .queue_ready (queue_ready)
    );

    thq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (queue_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (enable),
        .out_item  (queue_item)
    );

    thq_fetch #(
        .GRID_MAX (GRID_MAX)
    ) u_fetch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enable     (enable),
        .item_valid (queue_valid),
        .item       (queue_item),
        .grid_g     (grid_g),
        .fetch_o    (fetch_data)
    );

    thq_interp u_interp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fetch_i      (fetch_data),
        .height_scale (height_scale_reg),
        .enable       (enable),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

`default_nettype wire
